// ----- sv/fkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// fkvc_pkg: shared types and constants for the key-value cache
// Field widths, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package fkvc_pkg;

  // Fixed widths of the stream fields
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned STATUS_W = 3;

  // Request operation carried in the slave-side tuser
  typedef enum logic {
    FN_GET = 1'b0,
    FN_PUT = 1'b1
  } fkvc_func_e;

  // Result status carried in the master-side tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_GET_HIT   = 3'd0,
    ST_GET_MISS  = 3'd1,
    ST_PUT_UPD   = 3'd2,
    ST_PUT_INS   = 3'd3,
    ST_PUT_EVICT = 3'd4
  } fkvc_status_e;

  // Control word driven to each cell
  typedef struct packed {
    logic lookup;    // capture compare result against the search key
    logic shift;     // take key and value from the next cell up the row
    logic load_new;  // take the new key and value
    logic write_val; // overwrite the value only
  } fkvc_cell_ctl_t;

endpackage

`default_nettype wire

// ----- sv/fkvc_cell.sv -----
// ----------------------------------------------------------------------------
// fkvc_cell: one entry of the key-value row
// Holds a key and value, compares the key against the search key, and
// shifts down toward cell 0 (oldest) when the oldest entry is evicted.
// ----------------------------------------------------------------------------
`default_nettype none

module fkvc_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                           clk_i,
  input  fkvc_pkg::fkvc_cell_ctl_t      ctl_i,
  input  wire                           in_window_i,
  input  wire        [KEY_BITS-1:0]     cmp_key_i,
  input  wire        [KEY_BITS-1:0]     new_key_i,
  input  wire        [VALUE_BITS-1:0]   new_value_i,
  input  wire        [KEY_BITS-1:0]     next_key_i,
  input  wire        [VALUE_BITS-1:0]   next_value_i,
  output logic       [KEY_BITS-1:0]     key_o,
  output logic       [VALUE_BITS-1:0]   value_o,
  output logic                          match_o
);
  import fkvc_pkg::*;

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  match_q;

  // Load, shift or update the stored entry
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_new) begin
      key_q   <= new_key_i;
      value_q <= new_value_i;
    end else if (ctl_i.shift) begin
      key_q   <= next_key_i;
      value_q <= next_value_i;
    end else if (ctl_i.write_val) begin
      value_q <= new_value_i;
    end
  end

  // Capture the compare result for the update cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.lookup) begin
      match_q <= in_window_i && (key_q == cmp_key_i);
    end
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ----- sv/fifo_replacement_key_value_cache.sv -----
// ----------------------------------------------------------------------------
// fifo_replacement_key_value_cache: fully associative key-value store
// Row of entry cells kept in insertion order with oldest-first eviction.
// ----------------------------------------------------------------------------
// In the cycle a request word is accepted every cell compares its key against
// the request key; then, in the update state, the cells are updated and the
// result word is loaded into the output register. A new request is taken
// while the previous result still waits on the master side; a request stays
// in its update state only while an older result has not been taken. Cell 0
// always holds the oldest entry, so an eviction shifts the whole row down by
// one cell. No clearing pass is needed after reset: only cells below the
// occupancy count take part in a lookup.
`default_nettype none

module fifo_replacement_key_value_cache #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // capacity register
  input  wire                              cfg_we_i,
  input  wire  [fkvc_pkg::CAP_W-1:0]       cfg_wdata_i,
  // request stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [63:0]                      s_axis_tdata,  // key[31:0], value[63:32]
  input  wire  [0:0]                       s_axis_tuser,  // func[0]
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // read_value[31:0], evicted_key[63:32], hit_count[95:64],
  // miss_count[127:96], occupancy[132:128], zero pad[135:133]
  output logic [135:0]                     m_axis_tdata,
  output logic [fkvc_pkg::STATUS_W-1:0]    m_axis_tuser   // status[2:0]
);
  import fkvc_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_e;

  state_e                state_q;
  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      count_q;
  logic [COUNT_W-1:0]    hit_q;
  logic [COUNT_W-1:0]    miss_q;
  logic                  func_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [VALUE_W-1:0]    out_rval_q;
  logic [KEY_W-1:0]      out_ekey_q;
  logic [COUNT_W-1:0]    out_hit_q;
  logic [COUNT_W-1:0]    out_miss_q;
  logic [OCC_W-1:0]      out_occ_q;

  // Input field widths to storage widths
  logic [KEY_BITS+KEY_W-1:0]     key_wide;
  logic [VALUE_BITS+VALUE_W-1:0] value_wide;
  logic [KEY_BITS-1:0]           in_key;
  logic [VALUE_BITS-1:0]         in_value;
  logic                          accept;

  assign key_wide   = {{KEY_BITS{1'b0}}, s_axis_tdata[31:0]};
  assign value_wide = {{VALUE_BITS{1'b0}}, s_axis_tdata[63:32]};
  assign in_key     = key_wide[KEY_BITS-1:0];
  assign in_value   = value_wide[VALUE_BITS-1:0];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Cell row
  fkvc_cell_ctl_t        ctl      [ENTRIES];
  logic [KEY_BITS-1:0]   cell_key [ENTRIES];
  logic [VALUE_BITS-1:0] cell_val [ENTRIES];
  logic [ENTRIES-1:0]    match;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nkey;
    logic [VALUE_BITS-1:0] nval;
    if (i == ENTRIES - 1) begin : g_top
      assign nkey = cell_key[i];
      assign nval = cell_val[i];
    end else begin : g_mid
      assign nkey = cell_key[i+1];
      assign nval = cell_val[i+1];
    end
    fkvc_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl[i]),
      .in_window_i  (CNT_W'(i) < count_q),
      .cmp_key_i    (in_key),
      .new_key_i    (key_q),
      .new_value_i  (value_q),
      .next_key_i   (nkey),
      .next_value_i (nval),
      .key_o        (cell_key[i]),
      .value_o      (cell_val[i]),
      .match_o      (match[i])
    );
  end

  // Decide the outcome of the request in its update cycle
  logic                  go;
  logic                  found;
  logic                  evict;
  logic [VALUE_BITS-1:0] hit_val;
  logic [CW-1:0]         cap_ext;
  logic [CW-1:0]         eff_cap;
  logic [CW-1:0]         cnt_ext;
  logic [CNT_W-1:0]      count_d;
  logic [CW-1:0]         occ_ext;
  logic [STATUS_W-1:0]   status_d;
  logic [VALUE_BITS+VALUE_W-1:0] rval_wide;
  logic [KEY_BITS+KEY_W-1:0]     ekey_wide;

  assign go      = (state_q == S_UPDATE) && (!out_valid_q || m_axis_tready);
  assign found   = |match;
  assign cap_ext = CW'(cap_q);
  assign cnt_ext = CW'(count_q);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict = (func_q == FN_PUT) && !found && (cnt_ext >= eff_cap) && (count_q != '0);

  // Select the matching value (at most one cell matches)
  always_comb begin
    hit_val = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_val = hit_val | (match[i] ? cell_val[i] : '0);
    end
  end

  // Drive cell controls
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ctl[i].lookup    = accept;
      ctl[i].shift     = go && evict;
      ctl[i].write_val = go && (func_q == FN_PUT) && found && match[i];
      if (evict) begin
        ctl[i].load_new = go && (CNT_W'(i) == count_q - CNT_W'(1));
      end else begin
        ctl[i].load_new = go && (func_q == FN_PUT) && !found && (CNT_W'(i) == count_q);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if ((func_q == FN_PUT) && !found && !evict) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_comb begin
    case (func_q)
      FN_GET:  status_d = found ? ST_GET_HIT : ST_GET_MISS;
      FN_PUT:  status_d = found ? ST_PUT_UPD : (evict ? ST_PUT_EVICT : ST_PUT_INS);
      default: status_d = ST_GET_MISS;
    endcase
  end

  assign occ_ext   = CW'(count_d);
  assign rval_wide = {{VALUE_W{1'b0}},
                      ((func_q == FN_GET) && found) ? hit_val : {VALUE_BITS{1'b0}}};
  assign ekey_wide = {{KEY_W{1'b0}}, evict ? cell_key[0] : {KEY_BITS{1'b0}}};

  // Hold the capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(16);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Capture the request on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= s_axis_tuser[0];
      key_q   <= in_key;
      value_q <= in_value;
    end
  end

  // Sequence the request, keep counters, and hold the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      hit_q        <= '0;
      miss_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_rval_q   <= '0;
      out_ekey_q   <= '0;
      out_hit_q    <= '0;
      out_miss_q   <= '0;
      out_occ_q    <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && !go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (go) begin
            logic [COUNT_W-1:0] hit_n;
            logic [COUNT_W-1:0] miss_n;
            hit_n  = hit_q;
            miss_n = miss_q;
            if ((func_q == FN_GET) && found && !(&hit_q)) begin
              hit_n = hit_q + COUNT_W'(1);
            end
            if ((func_q == FN_GET) && !found && !(&miss_q)) begin
              miss_n = miss_q + COUNT_W'(1);
            end
            hit_q        <= hit_n;
            miss_q       <= miss_n;
            count_q      <= count_d;
            out_valid_q  <= 1'b1;
            out_status_q <= status_d;
            out_rval_q   <= rval_wide[VALUE_W-1:0];
            out_ekey_q   <= ekey_wide[KEY_W-1:0];
            out_hit_q    <= hit_n;
            out_miss_q   <= miss_n;
            out_occ_q    <= occ_ext[OCC_W-1:0];
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_miss_q, out_hit_q, out_ekey_q, out_rval_q};

endmodule

`default_nettype wire
